>>> rtl/hdbp_pkg.sv
// shared types, constants and decode functions of the hamming(31,26) decoder and byte packer
package hdbp_pkg;

  localparam int CwBits    = 31;
  localparam int DataBits  = 26;
  localparam int SynBits   = 5;
  localparam int ByteBits  = 8;
  localparam int LeftBits  = 6;
  localparam int CntBits   = 32;
  localparam int QueueDepth = 4;
  localparam int QPtrBits  = $clog2(QueueDepth);

  // one decoded codeword waiting for the packer
  typedef struct packed {
    logic [DataBits-1:0] data;
    logic [SynBits-1:0]  syn;
    logic                corr;
    logic [CntBits-1:0]  total;
  } entry_t;

  // syndrome bit i is the parity of every position whose index has bit i set
  function automatic logic [SynBits-1:0] syndrome_of(logic [CwBits-1:0] cw);
    logic [SynBits-1:0] s;
    s = '0;
    for (int i = 0; i < SynBits; i++) begin
      for (int pos = 1; pos <= CwBits; pos++) begin
        if (((pos >> i) & 1) == 1) begin
          s[i] = s[i] ^ cw[pos-1];
        end
      end
    end
    return s;
  endfunction

  // data positions in ascending order, first one ends up in the msb
  function automatic logic [DataBits-1:0] extract_data(logic [CwBits-1:0] cw);
    logic [DataBits-1:0] d;
    d = '0;
    for (int pos = 1; pos <= CwBits; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        d = {d[DataBits-2:0], cw[pos-1]};
      end
    end
    return d;
  endfunction

endpackage

>>> rtl/hamming_31_26_decoder_byte_packer.sv
// top level of the hamming(31,26) single-error-correcting decoder with byte packer
// Each codeword pushed in is decoded in the cycle it is taken: the 5-bit syndrome is
// formed, a nonzero syndrome flips that position and bumps a saturating 32-bit count of
// corrected codewords, and the 26 data bits are lifted out in position order. The
// decoded word goes into a four-entry queue; the packer behind it joins it to the 0, 2,
// 4 or 6 bits left over from earlier codewords and hands out one byte per cycle, msb
// first, through a single result register, while pop keeps that register drained. A
// codeword gives 3 or 4 bytes and holds the packer until the last of them; that
// byte-a-cycle packer sets the sustained rate. The queue entry is freed only on the
// last byte, so a burst of four codewords, or five when the packer drains a three-byte
// codeword meanwhile, can be taken in consecutive cycles before full rises. Every byte
// carries the syndrome, the corrected flag and the count after its codeword, and the
// final byte of each codeword has last_of_block set. Double errors are not detected.
// Reset clears leftover bits, the count and the queue; no clearing pass is needed.
module hamming_31_26_decoder_byte_packer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request side
  input  logic                             push,
  output logic                             full,
  input  logic [hdbp_pkg::CwBits-1:0]      codeword_i,
  // result side
  output logic                             empty,
  input  logic                             pop,
  output logic [hdbp_pkg::ByteBits-1:0]    data_byte_o,
  output logic                             last_of_block_o,
  output logic                             block_corrected_o,
  output logic [hdbp_pkg::SynBits-1:0]     error_position_o,
  output logic [hdbp_pkg::CntBits-1:0]     corrected_total_o
);

  logic             q_wr;
  logic             q_full;
  logic             q_rd;
  logic             q_empty;
  hdbp_pkg::entry_t q_wdata;
  hdbp_pkg::entry_t q_head;

  assign full = q_full;

  // decode and count
  hdbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .codeword_i (codeword_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr),
    .q_wdata_o  (q_wdata)
  );

  // decoded words wait here while the packer drains bytes
  hdbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_head),
    .empty_o (q_empty)
  );

  // byte packing and result register
  hdbp_packer u_packer (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (q_head),
    .head_empty_i      (q_empty),
    .head_rd_o         (q_rd),
    .pop               (pop),
    .empty             (empty),
    .data_byte_o       (data_byte_o),
    .last_of_block_o   (last_of_block_o),
    .block_corrected_o (block_corrected_o),
    .error_position_o  (error_position_o),
    .corrected_total_o (corrected_total_o)
  );

endmodule

>>> rtl/hdbp_front.sv
// front end: syndrome, single-bit correction, data extraction and correction counter
module hdbp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  input  logic [hdbp_pkg::CwBits-1:0]     codeword_i,
  input  logic                            q_full_i,
  output logic                            q_wr_o,
  output hdbp_pkg::entry_t                q_wdata_o
);

  logic [hdbp_pkg::SynBits-1:0] syn;
  logic                         corr;
  logic [hdbp_pkg::CwBits-1:0]  fixed_cw;
  logic [hdbp_pkg::CntBits-1:0] count_q, count_d;

  assign syn      = hdbp_pkg::syndrome_of(codeword_i);
  assign corr     = (syn != '0);
  assign fixed_cw = corr ? (codeword_i ^ (hdbp_pkg::CwBits'(1) << (syn - 5'd1))) : codeword_i;
  assign q_wr_o   = push & ~q_full_i;

  // saturating count of corrected codewords
  always_comb begin
    count_d = count_q;
    if (q_wr_o && corr && (count_q != '1)) begin
      count_d = count_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign q_wdata_o.data  = hdbp_pkg::extract_data(fixed_cw);
  assign q_wdata_o.syn   = syn;
  assign q_wdata_o.corr  = corr;
  assign q_wdata_o.total = count_d;

endmodule

>>> rtl/hdbp_queue.sv
// short queue of decoded codewords between front end and packer
module hdbp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  hdbp_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output hdbp_pkg::entry_t rdata_o,
  output logic             empty_o
);

  hdbp_pkg::entry_t                 mem_q [hdbp_pkg::QueueDepth];
  logic [hdbp_pkg::QPtrBits-1:0]    wr_ptr_q, rd_ptr_q;
  logic [hdbp_pkg::QPtrBits:0]      fill_q;

  assign full_o  = (fill_q == (hdbp_pkg::QPtrBits+1)'(hdbp_pkg::QueueDepth));
  assign empty_o = (fill_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/hdbp_packer.sv
// back end: packs data bits into result register bytes, one a cycle unless stalled
module hdbp_packer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hdbp_pkg::entry_t                 head_i,
  input  logic                             head_empty_i,
  output logic                             head_rd_o,
  input  logic                             pop,
  output logic                             empty,
  output logic [hdbp_pkg::ByteBits-1:0]    data_byte_o,
  output logic                             last_of_block_o,
  output logic                             block_corrected_o,
  output logic [hdbp_pkg::SynBits-1:0]     error_position_o,
  output logic [hdbp_pkg::CntBits-1:0]     corrected_total_o
);

  logic [hdbp_pkg::LeftBits-1:0] left_q, left_d;
  logic [2:0]                    left_cnt_q, left_cnt_d;
  logic [1:0]                    k_q, k_d;
  logic                          out_valid_q;

  logic [31:0] acc;
  logic [5:0]  total;
  logic [2:0]  nbytes;
  logic [2:0]  k_next;
  logic [5:0]  sh;
  logic [31:0] shifted;
  logic [2:0]  rem;
  logic [6:0]  mask;
  logic        last;
  logic        advance;

  assign acc     = {left_q, head_i.data};
  assign total   = {3'd0, left_cnt_q} + 6'd26;
  assign nbytes  = total[5:3];
  assign k_next  = {1'b0, k_q} + 3'd1;
  assign sh      = total - {k_next, 3'd0};
  assign shifted = acc >> sh;
  assign rem     = total[2:0];
  assign mask    = (7'd1 << rem) - 7'd1;
  assign last    = (k_next == nbytes);

  assign empty     = ~out_valid_q;
  assign advance   = ~head_empty_i & (~out_valid_q | pop);
  assign head_rd_o = advance & last;

  always_comb begin
    left_d     = left_q;
    left_cnt_d = left_cnt_q;
    k_d        = k_q;
    if (advance) begin
      if (last) begin
        left_d     = acc[hdbp_pkg::LeftBits-1:0] & mask[hdbp_pkg::LeftBits-1:0];
        left_cnt_d = rem;
        k_d        = '0;
      end else begin
        k_d = k_next[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      left_cnt_q  <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      left_q     <= left_d;
      left_cnt_q <= left_cnt_d;
      k_q        <= k_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      data_byte_o       <= shifted[hdbp_pkg::ByteBits-1:0];
      last_of_block_o   <= last;
      block_corrected_o <= head_i.corr;
      error_position_o  <= head_i.syn;
      corrected_total_o <= head_i.total;
    end
  end

endmodule
